// File: rtl/assert_macros.svh
// Assertion macros shared by the checker files.
// No dependencies; take in with a plain include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked outside reset only.
`define CHK_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("checker assertion failed");

// Property checked at every edge, reset included.
`define CHK_ASSERT_ALL(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("checker assertion failed");

`endif

// File: rtl/thpc_pkg.sv
// Shared types, constants and arithmetic helpers for the sensor compensation block.
// No dependencies.
package thpc_pkg;

  localparam logic [2:0] CFG_TEMP       = 3'd0;
  localparam logic [2:0] CFG_PRESS_LOW  = 3'd1;
  localparam logic [2:0] CFG_PRESS_HIGH = 3'd2;
  localparam logic [2:0] CFG_PRESS_LAST = 3'd3;
  localparam logic [2:0] CFG_HUM        = 3'd4;

  localparam logic [19:0] MARK_TP = 20'h80000;
  localparam logic [15:0] MARK_H  = 16'h8000;

  localparam logic signed [31:0] HUM_MAX = 32'sd419430400;
  localparam int unsigned DIV_BITS = 64;
  localparam int unsigned FRONT_STAGES = 14;

  typedef struct packed {
    logic [47:0] temp;
    logic [63:0] press_lo;
    logic [63:0] press_hi;
    logic [15:0] press_last;
    logic [63:0] hum;
  } cal_t;

  typedef struct packed {
    logic        mark;
    logic [15:0] temp;
    logic [16:0] hum;
  } side_t;

  typedef struct packed {
    logic [63:0] lo;
    logic [31:0] mid;
  } pp_t;

  // Sign-extend the low w bits of v.
  function automatic logic signed [31:0] sx32(input logic [31:0] v, input int unsigned w);
    logic signed [31:0] t;
    t = signed'(v << (32 - w));
    return t >>> (32 - w);
  endfunction

  // a * b modulo 2^64, b a signed 17-bit value, as two narrow partial products.
  function automatic logic signed [63:0] mul64x16(input logic [63:0] a,
                                                  input logic signed [16:0] b);
    logic signed [49:0] lo;
    logic signed [48:0] hi;
    lo = signed'({1'b0, a[31:0]}) * b;
    hi = signed'(a[63:32]) * b;
    return signed'(64'(lo) + {hi[31:0], 32'd0});
  endfunction

  // Partial products of a 64 x 64 product modulo 2^64.
  function automatic pp_t mul_pp(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] plo;
    logic [31:0] pmid;
    plo  = a[31:0] * b[31:0];
    pmid = a[31:0] * b[63:32] + a[63:32] * b[31:0];
    return '{lo: plo, mid: pmid};
  endfunction

endpackage

// File: rtl/thpc_if.sv
// Valid/ready channel interfaces for raw samples and compensated results.
// No dependencies.
interface thpc_in_if;
  logic        valid;
  logic        ready;
  logic [19:0] raw_temp;
  logic [19:0] raw_press;
  logic [15:0] raw_hum;
  modport source (output valid, output raw_temp, output raw_press, output raw_hum,
                  input ready);
  modport sink (input valid, input raw_temp, input raw_press, input raw_hum,
                output ready);
endinterface

interface thpc_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] temperature;
  logic [31:0]        pressure;
  logic [16:0]        humidity;
  logic               status;
  modport source (output valid, output temperature, output pressure, output humidity,
                  output status, input ready);
  modport sink (input valid, input temperature, input pressure, input humidity,
                input status, output ready);
endinterface

// File: rtl/thpc_front.sv
// Front pipeline: temperature, humidity and the pressure terms up to the divide.
// Depends on thpc_pkg.
module thpc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic [19:0]         raw_temp,
  input  logic [19:0]         raw_press,
  input  logic [15:0]         raw_hum,
  input  thpc_pkg::cal_t      cal,
  output logic                out_valid,
  output thpc_pkg::side_t     side,
  output logic signed [63:0]  num,
  output logic signed [63:0]  den
);

  logic v_r [1:14];
  logic mk_r [1:14];
  logic [19:0] rp_r [1:8];
  logic [15:0] rh_r [1:5];
  logic [15:0] t_r [5:14];
  logic signed [31:0] hx_r [7:10];
  logic signed [31:0] hp_r [11:13];
  logic signed [63:0] num_r [10:14];
  logic signed [63:0] den_r [10:14];

  logic signed [31:0] s1_r, d1_r, m1_r, dd_r, va_r, m2_r, tf_r, hv_r;
  logic signed [63:0] e1_r, sq_r, e1p5_r, e1p2_r, e1p5b_r, e1p2b_r;
  logic signed [63:0] sqp6_r, sqp3_r, e2_r, xb_r, y_r, num0_r;
  logic signed [31:0] xa_r, ym_r, zm_r, hy0_r, hz_r, hy1_r, hy2m_r, hy2_r, ww_r, q_r;
  logic [16:0] hum_r;

  logic signed [31:0] a, t1, t2, t3, tm, tt, w, rr;
  logic signed [31:0] h2, h4, h5, h6, h3, h1;
  logic signed [33:0] e1s;
  logic signed [67:0] sqw;
  logic signed [16:0] p2, p3, p5, p6;
  logic signed [63:0] p4;
  logic signed [31:0] s1_nxt, d1_nxt, m1_nxt, dd_nxt, va_nxt, m2_nxt, tf_nxt, hv_nxt;
  logic [15:0] t5_nxt;
  logic signed [63:0] e1_nxt, e1p5_nxt, e1p2_nxt, sqp6_nxt, sqp3_nxt, e2_nxt, xb_nxt;
  logic signed [63:0] y_nxt, num0_nxt, num_nxt, den_nxt;
  logic signed [31:0] xa_nxt, ym_nxt, zm_nxt, hx_nxt, hy0_nxt, hz_nxt, hy1_nxt;
  logic signed [31:0] hy2m_nxt, hy2_nxt, hp_nxt, ww_nxt, q_nxt;
  logic [16:0] hum_nxt;
  logic mk_nxt;

  always_comb begin
    t1 = signed'({16'd0, cal.temp[15:0]});
    t2 = thpc_pkg::sx32({16'd0, cal.temp[31:16]}, 16);
    t3 = thpc_pkg::sx32({16'd0, cal.temp[47:32]}, 16);
    p2 = 17'(signed'(cal.press_lo[31:16]));
    p3 = 17'(signed'(cal.press_lo[47:32]));
    p4 = 64'(signed'(cal.press_lo[63:48]));
    p5 = 17'(signed'(cal.press_hi[15:0]));
    p6 = 17'(signed'(cal.press_hi[31:16]));
    h1 = signed'({24'd0, cal.hum[7:0]});
    h2 = thpc_pkg::sx32({16'd0, cal.hum[23:8]}, 16);
    h3 = signed'({24'd0, cal.hum[31:24]});
    h4 = thpc_pkg::sx32({20'd0, cal.hum[43:32]}, 12);
    h5 = thpc_pkg::sx32({20'd0, cal.hum[55:44]}, 12);
    h6 = thpc_pkg::sx32({24'd0, cal.hum[63:56]}, 8);

    // stage 1
    a      = signed'({12'd0, raw_temp});
    s1_nxt = (a >>> 3) - (t1 <<< 1);
    d1_nxt = (a >>> 4) - t1;
    mk_nxt = (raw_temp == thpc_pkg::MARK_TP) || (raw_press == thpc_pkg::MARK_TP) ||
             (raw_hum == thpc_pkg::MARK_H);
    // stages 2 to 4: fine temperature
    m1_nxt = s1_r * t2;
    dd_nxt = d1_r * d1_r;
    va_nxt = m1_r >>> 11;
    m2_nxt = (dd_r >>> 12) * t3;
    tf_nxt = va_r + (m2_r >>> 14);
    // stage 5: rounded temperature, offsets for pressure and humidity
    tm = tf_r * 32'sd5 + 32'sd128;
    tt = tm >>> 8;
    if (tt > 32'sd32767) begin
      t5_nxt = 16'h7FFF;
    end else if (tt < -32'sd32768) begin
      t5_nxt = 16'h8000;
    end else begin
      t5_nxt = tt[15:0];
    end
    e1_nxt = 64'(tf_r) - 64'sd128000;
    hv_nxt = tf_r - 32'sd76800;
    // stage 6
    e1s      = signed'(e1_r[33:0]);
    sqw      = e1s * e1s;
    e1p5_nxt = e1s * p5;
    e1p2_nxt = e1s * p2;
    xa_nxt   = signed'({2'd0, rh_r[5], 14'd0}) - (h4 <<< 20) - h5 * hv_r;
    ym_nxt   = hv_r * h6;
    zm_nxt   = hv_r * h3;
    // stage 7
    sqp6_nxt = thpc_pkg::mul64x16(sq_r, p6);
    sqp3_nxt = thpc_pkg::mul64x16(sq_r, p3);
    hx_nxt   = (xa_r + 32'sd16384) >>> 15;
    hy0_nxt  = ym_r >>> 10;
    hz_nxt   = (zm_r >>> 11) + 32'sd32768;
    // stage 8
    e2_nxt  = sqp6_r + (e1p5b_r <<< 17) + (p4 <<< 35);
    xb_nxt  = 64'sh0000_8000_0000_0000 + (sqp3_r >>> 8) + (e1p2b_r <<< 12);
    hy1_nxt = ((hy0_r * hz_r) >>> 10) + 32'sd2097152;
    // stage 9
    y_nxt    = thpc_pkg::mul64x16(xb_r, signed'({1'b0, cal.press_lo[15:0]}));
    num0_nxt = ((64'sd1048576 - signed'({44'd0, rp_r[8]})) <<< 31) - e2_r;
    hy2m_nxt = hy1_r * h2;
    // stage 10
    den_nxt = y_r >>> 33;
    num_nxt = thpc_pkg::mul64x16(num0_r, 17'sd3125);
    hy2_nxt = (hy2m_r + 32'sd8192) >>> 14;
    // stages 11 to 14: humidity tail
    hp_nxt = hx_r[10] * hy2_r;
    w      = hp_r[11] >>> 15;
    ww_nxt = w * w;
    q_nxt  = ((ww_r >>> 7) * h1) >>> 4;
    rr     = hp_r[13] - q_r;
    if (rr < 32'sd0) begin
      rr = 32'sd0;
    end else if (rr > thpc_pkg::HUM_MAX) begin
      rr = thpc_pkg::HUM_MAX;
    end
    hum_nxt = rr[28:12];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 1; i <= 14; i++) v_r[i] <= 1'b0;
    end else if (en) begin
      v_r[1] <= in_valid;
      for (int i = 2; i <= 14; i++) v_r[i] <= v_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mk_r[1] <= mk_nxt;
      for (int i = 2; i <= 14; i++) mk_r[i] <= mk_r[i-1];
      rp_r[1] <= raw_press;
      for (int i = 2; i <= 8; i++) rp_r[i] <= rp_r[i-1];
      rh_r[1] <= raw_hum;
      for (int i = 2; i <= 5; i++) rh_r[i] <= rh_r[i-1];
      t_r[5] <= t5_nxt;
      for (int i = 6; i <= 14; i++) t_r[i] <= t_r[i-1];
      hx_r[7] <= hx_nxt;
      for (int i = 8; i <= 10; i++) hx_r[i] <= hx_r[i-1];
      hp_r[11] <= hp_nxt;
      for (int i = 12; i <= 13; i++) hp_r[i] <= hp_r[i-1];
      num_r[10] <= num_nxt;
      den_r[10] <= den_nxt;
      for (int i = 11; i <= 14; i++) begin
        num_r[i] <= num_r[i-1];
        den_r[i] <= den_r[i-1];
      end
      s1_r    <= s1_nxt;
      d1_r    <= d1_nxt;
      m1_r    <= m1_nxt;
      dd_r    <= dd_nxt;
      va_r    <= va_nxt;
      m2_r    <= m2_nxt;
      tf_r    <= tf_nxt;
      e1_r    <= e1_nxt;
      hv_r    <= hv_nxt;
      sq_r    <= sqw[63:0];
      e1p5_r  <= e1p5_nxt;
      e1p2_r  <= e1p2_nxt;
      xa_r    <= xa_nxt;
      ym_r    <= ym_nxt;
      zm_r    <= zm_nxt;
      sqp6_r  <= sqp6_nxt;
      sqp3_r  <= sqp3_nxt;
      e1p5b_r <= e1p5_r;
      e1p2b_r <= e1p2_r;
      hy0_r   <= hy0_nxt;
      hz_r    <= hz_nxt;
      e2_r    <= e2_nxt;
      xb_r    <= xb_nxt;
      hy1_r   <= hy1_nxt;
      y_r     <= y_nxt;
      num0_r  <= num0_nxt;
      hy2m_r  <= hy2m_nxt;
      hy2_r   <= hy2_nxt;
      ww_r    <= ww_nxt;
      q_r     <= q_nxt;
      hum_r   <= hum_nxt;
    end
  end

  assign out_valid = v_r[thpc_pkg::FRONT_STAGES];
  assign side      = '{mark: mk_r[14], temp: t_r[14], hum: hum_r};
  assign num       = num_r[14];
  assign den       = den_r[14];

endmodule

// File: rtl/thpc_div.sv
// Pipelined signed 64-bit divider, one quotient bit per stage, truncating toward zero.
// Depends on thpc_pkg.
module thpc_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic signed [63:0]  num,
  input  logic signed [63:0]  den,
  input  thpc_pkg::side_t     side_in,
  output logic                out_valid,
  output logic signed [63:0]  quo,
  output logic                den_zero,
  output thpc_pkg::side_t     side_out
);

  localparam int unsigned N = thpc_pkg::DIV_BITS;

  logic            v_r    [0:N+1];
  logic [63:0]     rem_r  [0:N];
  logic [63:0]     dvd_r  [0:N];
  logic [63:0]     da_r   [0:N];
  logic            neg_r  [0:N];
  logic            dz_r   [0:N+1];
  thpc_pkg::side_t side_r [0:N+1];
  logic signed [63:0] quo_r;

  // Magnitudes in, sign fixed up after the last step.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= '0;
      dvd_r[0]  <= num[63] ? 64'(-num) : 64'(num);
      da_r[0]   <= den[63] ? 64'(-den) : 64'(den);
      neg_r[0]  <= num[63] ^ den[63];
      dz_r[0]   <= (den == 64'sd0);
      side_r[0] <= side_in;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    logic [64:0] trial;
    logic [63:0] rem_nxt;
    logic        qbit;

    always_comb begin
      trial = {rem_r[i], dvd_r[i][63]} - {1'b0, da_r[i]};
      qbit  = ~trial[64];
      if (qbit) begin
        rem_nxt = trial[63:0];
      end else begin
        rem_nxt = {rem_r[i][62:0], dvd_r[i][63]};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (en) begin
        v_r[i+1] <= v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i+1]  <= rem_nxt;
        dvd_r[i+1]  <= {dvd_r[i][62:0], qbit};
        da_r[i+1]   <= da_r[i];
        neg_r[i+1]  <= neg_r[i];
        dz_r[i+1]   <= dz_r[i];
        side_r[i+1] <= side_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[N+1] <= 1'b0;
    end else if (en) begin
      v_r[N+1] <= v_r[N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo_r       <= neg_r[N] ? -signed'(dvd_r[N]) : signed'(dvd_r[N]);
      dz_r[N+1]   <= dz_r[N];
      side_r[N+1] <= side_r[N];
    end
  end

  assign out_valid = v_r[N+1];
  assign quo       = quo_r;
  assign den_zero  = dz_r[N+1];
  assign side_out  = side_r[N+1];

endmodule

// File: rtl/thpc_back.sv
// Back pipeline: pressure correction after the divide and the result register.
// Depends on thpc_pkg.
module thpc_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  logic signed [63:0] quo,
  input  logic               den_zero,
  input  thpc_pkg::side_t    side,
  input  thpc_pkg::cal_t     cal,
  output logic               out_valid,
  output logic signed [15:0] temperature,
  output logic [31:0]        pressure,
  output logic [16:0]        humidity,
  output logic               status
);

  logic v_r [1:4];
  logic signed [63:0] p_r [1:2];
  logic dz_r [1:3];
  thpc_pkg::side_t side_r [1:3];
  logic signed [63:0] ps_r, m1_r, m8_r, m8b_r, sum_r;
  thpc_pkg::pp_t pp_r;
  logic signed [15:0] temp_r;
  logic [31:0] press_r;
  logic [16:0] hum_r;
  logic status_r;

  logic signed [63:0] ps_nxt, m1_nxt, m8_nxt, prod, e1, e2, sum_nxt, pr;
  logic signed [16:0] p8, p9;
  logic signed [63:0] p7;

  always_comb begin
    p7 = 64'(signed'(cal.press_hi[47:32]));
    p8 = 17'(signed'(cal.press_hi[63:48]));
    p9 = 17'(signed'(cal.press_last));
    ps_nxt  = quo >>> 13;
    m1_nxt  = thpc_pkg::mul64x16(ps_nxt, p9);
    m8_nxt  = thpc_pkg::mul64x16(quo, p8);
    prod    = signed'(pp_r.lo + {pp_r.mid, 32'd0});
    e1      = prod >>> 25;
    e2      = m8b_r >>> 19;
    sum_nxt = p_r[2] + e1 + e2;
    pr      = (sum_r >>> 8) + (p7 <<< 4);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 1; i <= 4; i++) v_r[i] <= 1'b0;
    end else if (en) begin
      v_r[1] <= in_valid;
      for (int i = 2; i <= 4; i++) v_r[i] <= v_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r[1]    <= quo;
      p_r[2]    <= p_r[1];
      dz_r[1]   <= den_zero;
      side_r[1] <= side;
      for (int i = 2; i <= 3; i++) begin
        dz_r[i]   <= dz_r[i-1];
        side_r[i] <= side_r[i-1];
      end
      ps_r  <= ps_nxt;
      m1_r  <= m1_nxt;
      m8_r  <= m8_nxt;
      pp_r  <= thpc_pkg::mul_pp(m1_r, ps_r);
      m8b_r <= m8_r;
      sum_r <= sum_nxt;
      // marker sets status and drops temperature, humidity and pressure to zero
      status_r <= side_r[3].mark;
      temp_r   <= side_r[3].mark ? 16'sd0 : signed'(side_r[3].temp);
      hum_r    <= side_r[3].mark ? 17'd0 : side_r[3].hum;
      press_r  <= (side_r[3].mark || dz_r[3]) ? 32'd0 : pr[31:0];
    end
  end

  assign out_valid   = v_r[4];
  assign temperature = temp_r;
  assign pressure    = press_r;
  assign humidity    = hum_r;
  assign status      = status_r;

endmodule

// File: rtl/thp_sensor_compensation_top.sv
// Sensor compensation top level: calibration registers, front, divider and back pipelines.
// Depends on thpc_pkg, thpc_if, thpc_front, thpc_div and thpc_back.
//
// Use: raw sample triples arrive on in_ch (valid/ready), compensated results leave on
// out_ch (valid/ready). A transfer happens at a rising edge with valid and ready high.
// Calibration words are to be written through cfg_we/cfg_index/cfg_wdata only while no sample
// is in flight (the block does not enforce this); an index beyond the list is ignored.
// Stages: 14 front stages, 66 divider stages with one quotient bit per divide step,
// 4 back stages, between the input transfer and out_ch.valid.
// Throughput: one sample per cycle while out_ch.ready stays high.
// Stall: the whole pipeline holds while a result sits unread in the output register;
// in_ch.ready follows that same enable, so nothing is lost or repeated.
// Reset (rst_n low, synchronous): all valid bits clear and calibration reads as zero.
// Marker samples come out with status set and all three values zero; a zero
// pressure divisor gives a zero pressure field.
module thp_sensor_compensation_top (
  input  logic              clk,
  input  logic              rst_n,
  thpc_in_if.sink           in_ch,
  thpc_out_if.source        out_ch,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [63:0]       cfg_wdata
);

  thpc_pkg::cal_t cal_r;
  thpc_pkg::side_t front_side, div_side;
  logic en;
  logic front_valid, div_valid, div_zero;
  logic signed [63:0] front_num, front_den, div_quo;

  // advance everything unless the result register is full and stalled
  assign en          = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  // calibration registers, bits above a register's width dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        thpc_pkg::CFG_TEMP:       cal_r.temp       <= cfg_wdata[47:0];
        thpc_pkg::CFG_PRESS_LOW:  cal_r.press_lo   <= cfg_wdata;
        thpc_pkg::CFG_PRESS_HIGH: cal_r.press_hi   <= cfg_wdata;
        thpc_pkg::CFG_PRESS_LAST: cal_r.press_last <= cfg_wdata[15:0];
        thpc_pkg::CFG_HUM:        cal_r.hum        <= cfg_wdata;
        default: ;
      endcase
    end
  end

  thpc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_ch.valid),
    .raw_temp  (in_ch.raw_temp),
    .raw_press (in_ch.raw_press),
    .raw_hum   (in_ch.raw_hum),
    .cal       (cal_r),
    .out_valid (front_valid),
    .side      (front_side),
    .num       (front_num),
    .den       (front_den)
  );

  thpc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (front_valid),
    .num       (front_num),
    .den       (front_den),
    .side_in   (front_side),
    .out_valid (div_valid),
    .quo       (div_quo),
    .den_zero  (div_zero),
    .side_out  (div_side)
  );

  thpc_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_valid    (div_valid),
    .quo         (div_quo),
    .den_zero    (div_zero),
    .side        (div_side),
    .cal         (cal_r),
    .out_valid   (out_ch.valid),
    .temperature (out_ch.temperature),
    .pressure    (out_ch.pressure),
    .humidity    (out_ch.humidity),
    .status      (out_ch.status)
  );

endmodule

// File: rtl/thpc_checker.sv
// Port-level checker for the sensor compensation top level, attached by bind.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module thpc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] temperature,
  input logic [31:0]        pressure,
  input logic [16:0]        humidity,
  input logic               status
);

  // whole result word, status in the lowest bit
  logic [65:0] out_word;

  assign out_word = {temperature, pressure, humidity, status};

  `CHK_ASSERT_ALL(a_reset_empty, clk, !rst_n |=> !out_valid)
  `CHK_ASSERT(a_stall_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_word))
  `CHK_ASSERT(a_backpressure, clk, rst_n, out_valid && !out_ready |-> !in_ready)
  `CHK_ASSERT(a_marker_zero, clk, rst_n, out_valid && status |-> out_word == 66'd1)
  `CHK_ASSERT(a_hum_range, clk, rst_n, out_valid |-> humidity <= 17'd102400)

endmodule

bind thp_sensor_compensation_top thpc_checker u_thpc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .temperature (out_ch.temperature),
  .pressure    (out_ch.pressure),
  .humidity    (out_ch.humidity),
  .status      (out_ch.status)
);
